>>> sv/pgdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgdm_pkg: shared types and constants of the power-good debounce monitor
// Request payloads, result payloads, command codes and register indexes.
// ----------------------------------------------------------------------------
package pgdm_pkg;

  localparam int MAX_RAILS = 16;            // rails with a debounce counter
  localparam int PG_W      = 16;            // width of the power-good field
  localparam int RAIL_W    = 4;             // width of a rail index
  localparam int RC_W      = 5;             // width of rail_count
  localparam int CNT_W     = 8;             // width of one low counter
  localparam int CFG_W     = 8;             // widest register
  localparam int CFG_IDX_W = 1;             // register index width

  // request kinds
  typedef enum logic [1:0] {
    KIND_POLL   = 2'd0,
    KIND_ARM    = 2'd1,
    KIND_DISARM = 2'd2
  } kind_t;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAIL_COUNT = 1'b0,
    CFG_DEBOUNCE   = 1'b1
  } cfg_idx_t;

  localparam logic [RC_W-1:0]  RAIL_COUNT_RST = RC_W'(16);
  localparam logic [CNT_W-1:0] DEBOUNCE_RST   = CNT_W'(3);
  localparam logic [CNT_W-1:0] CNT_MAX        = '1;

  typedef struct packed {
    logic [1:0]      kind;
    logic [PG_W-1:0] pg_levels;
  } in_t;

  typedef struct packed {
    logic              fault;
    logic [RAIL_W-1:0] fault_rail;
    logic              armed;
  } out_t;

  typedef logic [MAX_RAILS-1:0][CNT_W-1:0] cnt_arr_t;

endpackage

>>> sv/pgdm_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgdm_step: one-request update of the rail counters and armed flag
// Parallel per-rail counter update with a lowest-index fault priority pick.
// ----------------------------------------------------------------------------
module pgdm_step (
  input  pgdm_pkg::in_t                    req,
  input  logic                             armed,
  input  pgdm_pkg::cnt_arr_t               counts,
  input  logic [pgdm_pkg::RC_W-1:0]        rail_count,
  input  logic [pgdm_pkg::CNT_W-1:0]       debounce_polls,
  output pgdm_pkg::out_t                   res,
  output pgdm_pkg::cnt_arr_t               counts_nxt
);
  import pgdm_pkg::*;

  logic [RC_W-1:0]      n_scan;
  logic [MAX_RAILS-1:0] scan;
  logic [MAX_RAILS-1:0] low;
  logic [MAX_RAILS-1:0] hit;
  logic [MAX_RAILS-1:0] first_hit;
  logic [MAX_RAILS-1:0] upd;
  cnt_arr_t             inc;
  cnt_arr_t             poll_cnt;
  logic [RAIL_W-1:0]    hit_idx;
  logic                 arm_ok;

  assign n_scan = (rail_count > RC_W'(MAX_RAILS)) ? RC_W'(MAX_RAILS) : rail_count;
  assign arm_ok = (rail_count != '0) && (rail_count <= RC_W'(MAX_RAILS));

  for (genvar i = 0; i < MAX_RAILS; i++) begin : g_rail
    if (i < PG_W) begin : g_pg
      assign low[i] = ~req.pg_levels[i];
    end else begin : g_nopg
      assign low[i] = 1'b1;   // rails past the PG field read low
    end
    assign scan[i] = RC_W'(i) < n_scan;
    assign inc[i]  = (counts[i] == CNT_MAX) ? counts[i] : counts[i] + CNT_W'(1);
    assign hit[i]  = scan[i] & low[i] & (inc[i] >= debounce_polls);
    assign poll_cnt[i] = (scan[i] & upd[i]) ? (low[i] ? inc[i] : '0) : counts[i];
  end

  // isolate lowest fault; rails above it keep their counts
  assign first_hit = hit & (~hit + MAX_RAILS'(1));
  assign upd       = (hit == '0) ? '1 : (first_hit | (first_hit - MAX_RAILS'(1)));

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < MAX_RAILS; i++) begin
      if (first_hit[i]) begin
        hit_idx = hit_idx | RAIL_W'(i);
      end
    end
  end

  always_comb begin
    res        = '0;
    res.armed  = armed;
    counts_nxt = counts;
    case (req.kind)
      KIND_ARM: begin
        if (arm_ok) begin
          counts_nxt = '0;
          res.armed  = 1'b1;
        end
      end
      KIND_DISARM: begin
        res.armed = 1'b0;
      end
      KIND_POLL: begin
        if (armed) begin
          counts_nxt = poll_cnt;
          if (hit != '0) begin
            res.fault      = 1'b1;
            res.fault_rail = hit_idx;
            res.armed      = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> sv/power_good_debounce_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_good_debounce_monitor: debounced power-good loss detector
// Per-rail low counters, arm/disarm control and one-shot fault report.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry requests: poll (PG levels), arm, disarm.
//   out_valid/out_stall/out_data carry one result per request: fault flag,
//   failing rail index and the armed flag after that request.
//   cfg_we/cfg_index/cfg_wdata write rail_count (index 0) and
//   debounce_polls (index 1); write only while no request is in flight.
// Order: an accepted request sits in the input register, and its result is
//   then registered in the result register, from which it can be taken.
// Throughput: one request per cycle unless out_stall holds a result; every
//   rail counter and the priority pick of the lowest faulting rail update
//   together in one step between the input register and the result register.
// Reset (rst_n low, synchronous): both channels empty, counters zero,
//   block disarmed, rail_count 16, debounce_polls 3.
// Stall: while out_stall holds a result, the input register still fills
//   once; in_stall rises only when both registers are occupied.
// ----------------------------------------------------------------------------
module power_good_debounce_monitor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pgdm_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pgdm_pkg::out_t                out_data,
  input  logic                          cfg_we,
  input  logic [pgdm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pgdm_pkg::CFG_W-1:0]    cfg_wdata
);
  import pgdm_pkg::*;

  // input register
  logic     in_valid_r;
  in_t      in_data_r;
  // result register
  logic     out_valid_r;
  out_t     out_data_r;
  // block state
  logic     armed_r;
  cnt_arr_t counts_r;
  // configuration
  logic [RC_W-1:0]  rail_count_r;
  logic [CNT_W-1:0] debounce_r;

  out_t     res_nxt;
  cnt_arr_t counts_nxt;
  logic     advance;
  logic     accept;

  // result register frees up when empty or being taken
  assign advance  = ~out_valid_r | ~out_stall;
  assign in_stall = in_valid_r & ~advance;
  assign accept   = in_valid & ~in_stall;

  pgdm_step u_step (
    .req            (in_data_r),
    .armed          (armed_r),
    .counts         (counts_r),
    .rail_count     (rail_count_r),
    .debounce_polls (debounce_r),
    .res            (res_nxt),
    .counts_nxt     (counts_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      armed_r      <= 1'b0;
      counts_r     <= '0;
      rail_count_r <= RAIL_COUNT_RST;
      debounce_r   <= DEBOUNCE_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RAIL_COUNT: rail_count_r <= cfg_wdata[RC_W-1:0];
          CFG_DEBOUNCE:   debounce_r   <= cfg_wdata[CNT_W-1:0];
          default: begin
          end
        endcase
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
        if (in_valid_r) begin
          armed_r  <= res_nxt.armed;
          counts_r <= counts_nxt;
        end
      end
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      in_data_r <= in_data;
    end
    if (advance && in_valid_r) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/pgdm_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgdm_chk: port-level checks for the power-good debounce monitor
// Watches the result channel and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
module pgdm_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_stall,
  input pgdm_pkg::out_t out_data
);
  import pgdm_pkg::*;

  // a confirmed loss always disarms
  a_fault_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fault |-> !out_data.armed)
    else $error("fault reported while still armed");

  // rail index only meaningful with a fault
  a_rail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.fault |-> out_data.fault_rail == '0)
    else $error("fault_rail nonzero without fault");

  // reset empties the result channel
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind power_good_debounce_monitor pgdm_chk u_pgdm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the power-good debounce monitor
// Sends arm, disarm, poll and unused-kind requests under several rail_count
// and debounce_polls settings, with random gaps on both channels. A
// scoreboard predicts every result from its own copy of the counters and
// compares each result field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import pgdm_pkg::*;

  class pg_fault_scoreboard;
    logic [RC_W-1:0]  rail_count;
    logic [CNT_W-1:0] debounce;
    logic [CNT_W-1:0] low_cnt [MAX_RAILS];
    bit               armed;
    out_t             expected_q [$];
    int               errors;

    function new();
      rail_count = RAIL_COUNT_RST;
      debounce   = DEBOUNCE_RST;
      foreach (low_cnt[i]) low_cnt[i] = '0;
      armed  = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
      if (idx == CFG_RAIL_COUNT) begin
        rail_count = val[RC_W-1:0];
      end else begin
        debounce = val;
      end
    endfunction

    // Update the rail counters for one accepted request and queue its result.
    function void note_request(in_t req);
      out_t exp;
      int   n;
      bit   hit;
      exp = '0;
      hit = 1'b0;
      case (req.kind)
        KIND_ARM: begin
          if (rail_count != 0 && rail_count <= MAX_RAILS) begin
            foreach (low_cnt[i]) low_cnt[i] = '0;
            armed = 1'b1;
          end
        end
        KIND_DISARM: begin
          armed = 1'b0;
        end
        KIND_POLL: begin
          if (armed) begin
            n = (rail_count > MAX_RAILS) ? MAX_RAILS : rail_count;
            for (int i = 0; i < n && !hit; i++) begin
              if (req.pg_levels[i]) begin
                low_cnt[i] = '0;
              end else begin
                if (low_cnt[i] != CNT_MAX) low_cnt[i] = low_cnt[i] + CNT_W'(1);
                if (low_cnt[i] >= debounce) begin
                  armed          = 1'b0;
                  hit            = 1'b1;
                  exp.fault      = 1'b1;
                  exp.fault_rail = RAIL_W'(i);
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
      exp.armed = armed;
      expected_q.push_back(exp);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH %0d at %0t ns: %s", errors, $time, msg);
    endtask

    task check_result(out_t got);
      out_t exp;
      if (expected_q.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      exp = expected_q.pop_front();
      if (got.fault !== exp.fault)
        report($sformatf("fault got %0b want %0b", got.fault, exp.fault));
      if (got.fault_rail !== exp.fault_rail)
        report($sformatf("fault_rail got %0d want %0d", got.fault_rail, exp.fault_rail));
      if (got.armed !== exp.armed)
        report($sformatf("armed got %0b want %0b", got.armed, exp.armed));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // Kind 3 has no enum member in the package; the block must ignore it.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;   // watchdog limit on the whole run
  localparam int HOLD_CYCLES = 200;      // long receiver hold-off for back-pressure

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  pg_fault_scoreboard sb;
  int idle_pct   = 0;   // chance in percent that either side idles before a step
  bit hold_req   = 1'b0;
  int stall_left = 0;
  int cycle_cnt  = 0;

  power_good_debounce_monitor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Watchdog: anything that hangs ends here.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side. A hold request from the main flow turns into one long stall
  // counted here, so the sender keeps pushing while the block fills up.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (hold_req) begin
      stall_left = HOLD_CYCLES;
      hold_req   = 1'b0;
    end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      stall_left = gap_len();
    end
    out_stall <= (stall_left != 0);
  end

  // Values sampled here are the ones present just before the edge, so the
  // check does not depend on process order within the time step.
  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_stall === 1'b0) sb.check_result(out_data);
  end

  // Offer one request and hold it until the block takes it. in_valid is left
  // high after acceptance; drain_block or a gap in the next call lowers it, so it
  // sees only one nonblocking assignment per step.
  task send_req(logic [1:0] kind, logic [PG_W-1:0] pg);
    in_t req;
    int  gap;
    req.kind      = kind;
    req.pg_levels = pg;
    gap = (idle_pct != 0 && $urandom_range(99) < idle_pct) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(req);
  endtask

  // Stop sending and wait until every predicted result has come back, plus
  // the pipeline depth, before touching the registers.
  task drain_block();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers on back-to-back edges. The spare upper bits of the
  // rail_count word are random; only the low five bits count.
  task cfg_set(logic [RC_W-1:0] rc, logic [CFG_W-1:0] db);
    logic [CFG_W-1:0] rc_word;
    rc_word = CFG_W'($urandom);
    rc_word[RC_W-1:0] = rc;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RAIL_COUNT;
    cfg_wdata <= rc_word;
    @(posedge clk);
    sb.set_reg(CFG_RAIL_COUNT, rc_word);
    cfg_index <= CFG_DEBOUNCE;
    cfg_wdata <= db;
    @(posedge clk);
    sb.set_reg(CFG_DEBOUNCE, db);
    cfg_we <= 1'b0;
  endtask

  // PG word with one weak rail that reads low often; the rest mostly high.
  function logic [PG_W-1:0] gen_levels(int weak_rail, int weak_pct);
    logic [PG_W-1:0] pg;
    if ($urandom_range(99) < 10) return PG_W'($urandom);
    for (int i = 0; i < PG_W; i++) begin
      if (i == weak_rail) pg[i] = !($urandom_range(99) < weak_pct);
      else                pg[i] = !($urandom_range(99) < 4);
    end
    return pg;
  endfunction

  // One random phase: pick a setting, then mostly polls under an armed block
  // with some arm, disarm and unused-kind noise.
  task run_phase(int p);
    logic [RC_W-1:0]  rc;
    logic [CFG_W-1:0] db;
    int n_items, weak_rail, weak_pct, r;
    case (p % 6)
      0:       rc = RC_W'(16);
      1:       rc = RC_W'(1);
      2:       rc = RC_W'($urandom_range(2, 15));
      3:       rc = RC_W'($urandom_range(1, 16));
      4:       rc = ($urandom_range(1) == 0) ? 5'd0 : RC_W'($urandom_range(17, 31));
      default: rc = RC_W'($urandom_range(1, 16));
    endcase
    case (p % 5)
      0:       db = CFG_W'(0);
      1:       db = CFG_W'(1);
      2:       db = CNT_MAX;
      3:       db = CFG_W'($urandom_range(2, 6));
      default: db = CFG_W'($urandom_range(1, 20));
    endcase
    drain_block();
    cfg_set(rc, db);
    idle_pct  = (p % 4 == 0) ? 0 : 30;
    weak_rail = (rc >= 1 && rc <= MAX_RAILS) ? $urandom_range(0, rc - 1)
                                             : $urandom_range(0, MAX_RAILS - 1);
    // The longest debounce needs 255 unbroken low reads, so no noise there.
    weak_pct  = (db == CNT_MAX) ? 100 : $urandom_range(30, 90);
    n_items   = (db == CNT_MAX) ? 280 : 70;
    repeat (n_items) begin
      r = $urandom_range(99);
      if (db == CNT_MAX && sb.armed) r = 99;
      if (!sb.armed && r < 40)  send_req(KIND_ARM, PG_W'($urandom));
      else if (r < 3)           send_req(KIND_ARM, PG_W'($urandom));
      else if (r < 5)           send_req(KIND_DISARM, PG_W'($urandom));
      else if (r < 7)           send_req(KIND_UNUSED, PG_W'($urandom));
      else                      send_req(KIND_POLL, gen_levels(weak_rail, weak_pct));
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset settings (16 rails, debounce 3).
    idle_pct = 20;
    send_req(KIND_POLL,   16'h0000);   // disarmed: ignored
    send_req(KIND_UNUSED, 16'hFFFF);   // unused kind changes nothing
    send_req(KIND_ARM,    16'h0000);
    send_req(KIND_POLL,   16'hFFFF);
    send_req(KIND_POLL,   16'h0000);
    send_req(KIND_POLL,   16'h0000);
    send_req(KIND_POLL,   16'h0000);   // rail 0 confirmed lost, block disarms
    send_req(KIND_ARM,    16'hFFFF);
    send_req(KIND_POLL,   16'h7FFF);
    send_req(KIND_UNUSED, 16'h0000);   // unused kind while armed
    send_req(KIND_POLL,   16'hFFFF);   // high read clears the count
    send_req(KIND_POLL,   16'h7FFF);
    send_req(KIND_POLL,   16'h7FFF);
    send_req(KIND_POLL,   16'h7FFF);   // top rail confirmed lost
    send_req(KIND_ARM,    16'h0000);
    send_req(KIND_POLL,   16'h0000);
    send_req(KIND_DISARM, 16'hFFFF);   // disarm keeps the counts
    send_req(KIND_POLL,   16'h0000);   // ignored

    // One rail, zero debounce: first low read faults at once.
    drain_block();
    cfg_set(5'd1, 8'd0);
    send_req(KIND_ARM,    16'h0000);
    send_req(KIND_POLL,   16'h0001);   // rails above the count are ignored
    send_req(KIND_POLL,   16'hFFFE);

    // Zero rails: arm is refused.
    drain_block();
    cfg_set(5'd0, 8'd3);
    send_req(KIND_ARM,    16'h0000);

    // Threshold lowered while armed, rail_count of zero and above the limit.
    drain_block();
    cfg_set(5'd16, 8'd10);
    send_req(KIND_ARM,    16'h0000);
    repeat (5) send_req(KIND_POLL, 16'hFFFE);
    drain_block();
    cfg_set(5'd0, 8'd10);
    send_req(KIND_POLL,   16'h0000);   // armed, but no rail scanned
    drain_block();
    cfg_set(5'd31, 8'd2);
    send_req(KIND_ARM,    16'h0000);   // refused, counts survive
    send_req(KIND_POLL,   16'h0000);   // rail 0 already past the new threshold

    // Back-pressure: the receiver holds off while polls keep coming.
    drain_block();
    cfg_set(5'd16, CNT_MAX);
    idle_pct = 0;
    send_req(KIND_ARM, 16'h0000);
    hold_req = 1'b1;
    repeat (40) send_req(KIND_POLL, PG_W'($urandom) | 16'h0F0F);

    for (int p = 0; p < 12; p++) run_phase(p);

    drain_block();
    repeat (5) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
